>>> rtl/core/assert_macros.svh
// assertion macros used by the multi keyword matcher in the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition at one edge implies a condition at the next edge
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/mkm_pkg.sv
// shared types and constants of the multi keyword matcher
package mkm_pkg;

  // request command carried in s_tuser
  localparam logic CMD_MATCH   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // result kind carried in m_tuser
  typedef enum logic [1:0] {
    KIND_EOL    = 2'd0,
    KIND_NONE   = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_FOUND  = 2'd3
  } kind_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ZERO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_THREE = 3'd4;

  localparam int KEY_REGS   = 4;
  localparam int KEY_W      = 64;
  localparam int COUNT_W    = 3;
  localparam int FOUND_W    = 2;

  // end of line characters
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

endpackage

>>> rtl/core/multi_keyword_matcher.sv
// multi keyword prefix matcher: compares a character stream against up to four keywords
//
// Usage: keywords and key_count are written through the cfg port (cfg_we, cfg_index,
// cfg_wdata) while the stream is idle. Each request on the s_ channel carries a command
// in s_tuser and a character in s_tdata. A restart request marks every key live, sets
// the position to zero and gives no result. A match request gives one result on the m_
// channel: end of line, no key live, still searching with the live count, or found with
// the index of the first key that completed.
// Output: a result is registered and is valid in the cycle after its request is taken.
// Throughput: one request per cycle while the output is not stalled; all key comparators
// and the priority pick work in parallel between the request and the output register.
// Stall: the output register holds its result while m_tready is low; s_tready follows
// m_tready then, so no request is taken until the pending result leaves.
// Reset: rst clears the keywords and key_count, marks every key live, clears the
// position and empties the output register.
`include "assert_macros.svh"

module multi_keyword_matcher
  import mkm_pkg::*;
#(
  parameter int NUM_KEYS = 4,
  parameter int KEY_LEN  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] char_in
  input  logic                 s_tuser,   // [0] cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [1:0] key_found, [4:2] live_count, [7:5] zero
  output logic [1:0]           m_tuser    // [1:0] result_kind
);

  localparam int POS_W = $clog2(KEY_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(KEY_LEN);

  logic [COUNT_W-1:0]  key_count;
  logic [KEY_W-1:0]    key_regs [KEY_REGS];
  logic [NUM_KEYS-1:0] live_mask;
  logic [POS_W-1:0]    position;

  logic [7:0] key_bytes [NUM_KEYS][KEY_LEN+1];

  // keyword characters; beyond KEY_LEN and for keys without a register they read zero
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    for (genvar p = 0; p <= KEY_LEN; p++) begin : g_byte
      if (k < KEY_REGS && p < KEY_LEN) begin : g_reg
        assign key_bytes[k][p] = key_regs[k][8*p +: 8];
      end else begin : g_zero
        assign key_bytes[k][p] = 8'h00;
      end
    end
  end

  logic               s_accept;
  logic               is_end;
  logic [POS_W-1:0]   pos_after;
  logic [NUM_KEYS-1:0] examined;
  logic [NUM_KEYS-1:0] char_match;
  logic [NUM_KEYS-1:0] key_ends;
  logic [NUM_KEYS-1:0] live_mask_next;
  logic [POS_W-1:0]   position_next;
  logic               hit;
  logic [2:0]         hit_idx;
  logic [COUNT_W-1:0] live_cnt;
  kind_t              kind_next;

  assign s_tready  = !m_tvalid || m_tready;
  assign s_accept  = s_tvalid && s_tready;
  assign is_end    = (s_tdata == CHAR_LF) || (s_tdata == CHAR_CR) || (s_tdata == CHAR_NUL);
  assign pos_after = (position == POS_MAX) ? POS_MAX : position + 1'b1;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      examined[k]   = live_mask[k] && (COUNT_W'(k) < key_count);
      char_match[k] = key_bytes[k][position] == s_tdata;
      key_ends[k]   = key_bytes[k][pos_after] == 8'h00;
    end
  end

  // keys are taken in ascending order; the first completed key stops the scan
  always_comb begin
    hit            = 1'b0;
    hit_idx        = '0;
    live_cnt       = '0;
    live_mask_next = live_mask;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!hit && examined[k]) begin
        if (!char_match[k]) begin
          live_mask_next[k] = 1'b0;
        end else if (key_ends[k]) begin
          hit     = 1'b1;
          hit_idx = 3'(k);
        end else begin
          live_cnt = live_cnt + 1'b1;
        end
      end
    end
    position_next = hit ? position : pos_after;
    if (hit) begin
      kind_next = KIND_FOUND;
    end else if (live_cnt == '0) begin
      kind_next = KIND_NONE;
    end else begin
      kind_next = KIND_SEARCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      for (int i = 0; i < KEY_REGS; i++) begin
        key_regs[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_COUNT: key_count   <= cfg_wdata[COUNT_W-1:0];
        REG_KEY_ZERO:  key_regs[0] <= cfg_wdata;
        REG_KEY_ONE:   key_regs[1] <= cfg_wdata;
        REG_KEY_TWO:   key_regs[2] <= cfg_wdata;
        REG_KEY_THREE: key_regs[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kind_t              res_kind;
  logic [FOUND_W-1:0] res_found;
  logic [COUNT_W-1:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_mask <= '1;
      position  <= '0;
      m_tvalid  <= 1'b0;
    end else if (s_accept) begin
      if (s_tuser == CMD_RESTART) begin
        live_mask <= '1;
        position  <= '0;
        m_tvalid  <= 1'b0;
      end else begin
        m_tvalid <= 1'b1;
        if (!is_end) begin
          live_mask <= live_mask_next;
          position  <= position_next;
        end
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (is_end) begin
        res_kind  <= KIND_EOL;
        res_found <= '0;
        res_count <= '0;
      end else begin
        res_kind  <= kind_next;
        res_found <= hit ? hit_idx[FOUND_W-1:0] : '0;
        res_count <= (kind_next == KIND_SEARCH) ? live_cnt : '0;
      end
    end
  end

  assign m_tuser = res_kind;
  assign m_tdata = {3'b000, res_count, res_found};

  `ASSERT_NEXT(a_restart_clears, s_accept && s_tuser == CMD_RESTART,
               position == '0 && live_mask == '1, "restart did not clear state")
  `ASSERT_NEXT(a_match_gives_result, s_accept && s_tuser == CMD_MATCH,
               m_tvalid, "match request gave no result")
  `ASSERT_CLK(a_position_bound, position <= POS_MAX, "position beyond keyword length")
  `ASSERT_CLK(a_search_count, !(m_tvalid && m_tuser == KIND_SEARCH) ||
              (m_tdata[4:2] != 3'd0 && 32'(m_tdata[4:2]) <= NUM_KEYS),
              "search result with bad live count")

endmodule

>>> bench/tb_multi_keyword_matcher.sv
`timescale 1ns / 100ps
// testbench for the multi keyword matcher: keyword hits, end of line and random streams
module tb_multi_keyword_matcher
  import mkm_pkg::*;
();

  localparam int NUM_KEYS = 4;
  localparam int KEY_LEN = 8;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] found;
    logic [2:0] live;
  } match_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 s_tuser = CMD_MATCH;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic [1:0]           m_tuser;

  // predictor state
  logic [2:0]          key_count_reg;
  logic [KEY_W-1:0]    keywords[KEY_REGS];
  logic [NUM_KEYS-1:0] live_keys;
  logic [3:0]          char_pos;

  match_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int found_seen = 0;
  int quiet_cycles = 0;

  multi_keyword_matcher #(
    .NUM_KEYS(NUM_KEYS),
    .KEY_LEN (KEY_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] keyword_char(int k, int p);
    if (k >= KEY_REGS || p >= KEY_LEN) return 8'h00;
    return keywords[k][8*p +: 8];
  endfunction

  function automatic void predict_request(logic cmd, logic [7:0] ch);
    match_result_t r;
    int used;
    int n_live;
    r.kind = KIND_EOL;
    r.found = '0;
    r.live = '0;
    n_live = 0;
    if (cmd == CMD_RESTART) begin
      live_keys = '1;
      char_pos = '0;
      return;
    end
    if (ch == CHAR_LF || ch == CHAR_CR || ch == CHAR_NUL) begin
      pending_results.push_back(r);
      return;
    end
    used = (key_count_reg > NUM_KEYS) ? NUM_KEYS : key_count_reg;
    for (int k = 0; k < used; k++) begin
      if (!live_keys[k]) continue;
      if (keyword_char(k, char_pos) != ch) begin
        live_keys[k] = 1'b0;
      end else if (keyword_char(k, char_pos + 1) == 8'h00) begin
        // first completed key wins, later keys keep their live bits
        r.kind = KIND_FOUND;
        r.found = k[1:0];
        pending_results.push_back(r);
        return;
      end else begin
        n_live++;
      end
    end
    if (char_pos < KEY_LEN) char_pos++;
    if (n_live == 0) begin
      r.kind = KIND_NONE;
    end else begin
      r.kind = KIND_SEARCH;
      r.live = n_live[2:0];
    end
    pending_results.push_back(r);
  endfunction

  function automatic logic [7:0] random_key_char();
    if ($urandom_range(7) == 0) return 8'($urandom_range(1, 255));
    return 8'h41 + 8'($urandom_range(3));
  endfunction

  function automatic logic [KEY_W-1:0] random_keyword();
    logic [KEY_W-1:0] w;
    int len;
    w = '0;
    if ($urandom_range(15) == 0) len = 0;
    else if ($urandom_range(7) == 0) len = KEY_LEN;
    else len = $urandom_range(1, 4);
    for (int p = 0; p < len; p++) w[8*p +: 8] = random_key_char();
    // junk past the terminator must not matter
    if ($urandom_range(3) == 0) begin
      for (int p = len + 1; p < 8; p++) w[8*p +: 8] = 8'($urandom);
    end
    return w;
  endfunction

  task automatic config_write(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY_COUNT) key_count_reg = value[2:0];
    else if (idx <= REG_KEY_THREE) keywords[idx - 1] = value;
    @(posedge clk);
  endtask

  task automatic send_request(input logic cmd, input logic [7:0] ch);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= ch;
    do @(posedge clk); while (!s_tready);
    predict_request(cmd, ch);
    requests_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_after_reset();
    // no keys in use: every character leaves nothing live
    send_request(CMD_MATCH, 8'h41);
    send_request(CMD_MATCH, CHAR_NUL);
    wait_idle();
  endtask

  task automatic test_keyword_hits();
    config_write(REG_KEY_ZERO, 64'h5441);               // AT
    config_write(REG_KEY_ONE, 64'h45_5441);             // ATE
    config_write(REG_KEY_TWO, 64'h4B4F);                // OK
    config_write(REG_KEY_THREE, 64'h4847_4645_4443_4241); // full-length keyword
    config_write(REG_KEY_COUNT, 64'd4);
    send_request(CMD_RESTART, 8'h00);
    send_request(CMD_MATCH, 8'h41);
    send_request(CMD_MATCH, 8'h54);
    send_request(CMD_MATCH, 8'h54);  // found key reported again
    send_request(CMD_MATCH, CHAR_CR);
    send_request(CMD_RESTART, 8'h00);
    for (int i = 0; i < KEY_LEN; i++) send_request(CMD_MATCH, 8'h41 + 8'(i));
    // run past the end so the position saturates
    send_request(CMD_MATCH, 8'h5A);
    send_request(CMD_MATCH, 8'h5A);
    wait_idle();
  endtask

  task automatic test_extremes();
    config_write(REG_KEY_ZERO, '1);
    config_write(REG_KEY_ONE, '0);
    config_write(REG_KEY_COUNT, 64'd7);  // clamps to the number of keys
    config_write(3'd5, '1);
    config_write(3'd6, '1);
    config_write(3'd7, '1);
    send_request(CMD_RESTART, 8'hFF);
    for (int i = 0; i < KEY_LEN; i++) send_request(CMD_MATCH, 8'hFF);
    send_request(CMD_MATCH, CHAR_LF);
    wait_idle();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int first;
    int k;
    int len;
    int n;
    int pick;
    logic [7:0] c;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < KEY_REGS; i++) begin
      if ($urandom_range(7) == 0) config_write(REG_KEY_ZERO + 3'(i), {$urandom, $urandom});
      else config_write(REG_KEY_ZERO + 3'(i), random_keyword());
    end
    if ($urandom_range(1) == 0) config_write(3'($urandom_range(5, 7)), {$urandom, $urandom});
    config_write(REG_KEY_COUNT, ($urandom_range(3) == 0) ? 64'($urandom_range(7)) : 64'd4);
    first = requests_sent;
    while (requests_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        // usually restart, then walk one keyword, with the odd wrong character
        if ($urandom_range(9) != 0) send_request(CMD_RESTART, 8'($urandom));
        k = $urandom_range(KEY_REGS - 1);
        len = 0;
        while (len < KEY_LEN && keyword_char(k, len) != 8'h00) len++;
        n = $urandom_range(1, len + 2);
        for (int i = 0; i < n; i++) begin
          c = keyword_char(k, i);
          if (c == 8'h00 || $urandom_range(15) == 0) c = random_key_char();
          if ($urandom_range(29) == 0) c = CHAR_CR;
          send_request(CMD_MATCH, c);
        end
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0: send_request(CMD_MATCH, CHAR_LF);
          1: send_request(CMD_MATCH, CHAR_CR);
          default: send_request(CMD_MATCH, CHAR_NUL);
        endcase
      end else begin
        send_request(1'($urandom), 8'($urandom));
      end
    end
    wait_idle();
  endtask

  // result check, receiver stalls and watchdog
  always @(posedge clk) begin
    match_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: kind %0d", m_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.kind == KIND_FOUND) found_seen++;
        if (m_tuser != want.kind) begin
          $error("result_kind expected %s got %0d", want.kind.name(), m_tuser);
          mismatches++;
        end
        if (m_tdata[1:0] != want.found) begin
          $error("key_found expected %0d got %0d", want.found, m_tdata[1:0]);
          mismatches++;
        end
        if (m_tdata[4:2] != want.live) begin
          $error("live_count expected %0d got %0d", want.live, m_tdata[4:2]);
          mismatches++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    key_count_reg = '0;
    for (int i = 0; i < KEY_REGS; i++) keywords[i] = '0;
    live_keys = '1;
    char_pos = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_keyword_hits();
    test_extremes();
    test_random_phase(0, 0, 100);
    test_random_phase(84, 0, 100);
    test_random_phase(0, 84, 100);
    test_random_phase(12, 12, 100);
    repeat (5) @(posedge clk);
    $display("summary: %0d requests, %0d results checked, %0d keyword hits", requests_sent,
             results_seen, found_seen);
    $display("summary: directed keyword cases plus four random phases of sender/receiver idling");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
